>>> rtl/core/brf_pkg.sv
`default_nettype none
package brf_pkg;

  localparam int NODES     = 16;
  localparam int MAX_LINKS = 128;
  localparam int NODE_AW   = $clog2(NODES);
  localparam int NCNT_W    = $clog2(NODES + 1);
  localparam int LINK_AW   = $clog2(MAX_LINKS);
  localparam int LCNT_W    = $clog2(MAX_LINKS + 1);
  localparam int LINK_W    = 28;
  localparam logic [6:0] NODE_COUNT_RST = 7'd16;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_NODE  = 3'd3;
  localparam logic [2:0] ST_NEG_CYCLE = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         node_a;
    logic [5:0]         node_b;
    logic signed [15:0] link_cost;
  } brf_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         dest;
    logic               reachable;
    logic               is_local;
    logic signed [31:0] route_cost;
    logic [5:0]         next_hop;
    logic               last;
  } brf_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ADD0, S_ADD1, S_RM_RD, S_RM_CHK, S_BF_INIT, S_E0, S_E1,
    S_E2, S_E3, S_CHK, S_EM_RD, S_EM_DEC, S_WALK, S_EMIT
  } brf_state_e;

  typedef struct packed {
    logic       latch;
    logic       add_wr0;
    logic       add_wr1;
    logic       idx_clr;
    logic       rm_step;
    logic       rm_commit;
    logic       bf_init;
    logic       e1;
    logic       e2;
    logic       e3;
    logic       edge_skip;
    logic       pass_next;
    logic       em_init;
    logic       walk_init;
    logic       walk_step;
    logic       emit_row;
    logic       emit_stat;
    logic [2:0] stat_code;
  } brf_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       bad;
    logic       full;
    logic       i_end;
    logic       skip;
    logic       chk;
    logic       neg;
    logic       walk_need;
    logic       walk_fin;
    logic       d_last;
    logic       found;
  } brf_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/brf_ctrl.sv
`default_nettype none
module brf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire brf_pkg::brf_sts_t sts_i,
  output brf_pkg::brf_cmd_t      cmd_o
);
  import brf_pkg::*;

  brf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.req_type)
          REQ_ADD: begin
            if (sts_i.bad) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat_code = ST_BAD_NODE;
              state_d         = S_IDLE;
            end else if (sts_i.full) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat_code = ST_FULL;
              state_d         = S_IDLE;
            end else begin
              state_d = S_ADD0;
            end
          end
          REQ_REMOVE: begin
            if (sts_i.bad) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat_code = ST_BAD_NODE;
              state_d         = S_IDLE;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_RM_RD;
            end
          end
          REQ_COMPUTE: begin
            if (sts_i.bad) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat_code = ST_BAD_NODE;
              state_d         = S_IDLE;
            end else begin
              state_d = S_BF_INIT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD0: begin
        cmd_o.add_wr0 = 1'b1;
        state_d       = S_ADD1;
      end
      S_ADD1: begin
        cmd_o.add_wr1   = 1'b1;
        cmd_o.emit_stat = 1'b1;
        cmd_o.stat_code = ST_OK;
        state_d         = S_IDLE;
      end
      S_RM_RD: begin
        if (sts_i.i_end) begin
          cmd_o.rm_commit = 1'b1;
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_code = sts_i.found ? ST_OK : ST_NOT_FOUND;
          state_d         = S_IDLE;
        end else begin
          state_d = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        cmd_o.rm_step = 1'b1;
        state_d       = S_RM_RD;
      end
      S_BF_INIT: begin
        cmd_o.bf_init = 1'b1;
        state_d       = S_E0;
      end
      S_E0: begin
        // end of pass: go on to the next pass or finish the check pass
        if (sts_i.i_end) begin
          if (sts_i.chk) begin
            state_d = S_CHK;
          end else begin
            cmd_o.pass_next = 1'b1;
          end
        end else begin
          state_d = S_E1;
        end
      end
      S_E1: begin
        if (sts_i.skip) begin
          cmd_o.edge_skip = 1'b1;
          state_d         = S_E0;
        end else begin
          cmd_o.e1 = 1'b1;
          state_d  = S_E2;
        end
      end
      S_E2: begin
        cmd_o.e2 = 1'b1;
        state_d  = S_E3;
      end
      S_E3: begin
        cmd_o.e3 = 1'b1;
        state_d  = S_E0;
      end
      S_CHK: begin
        if (sts_i.neg) begin
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_code = ST_NEG_CYCLE;
          state_d         = S_IDLE;
        end else begin
          cmd_o.em_init = 1'b1;
          state_d       = S_EM_RD;
        end
      end
      S_EM_RD: begin
        cmd_o.walk_init = 1'b1;
        state_d         = S_EM_DEC;
      end
      S_EM_DEC: begin
        state_d = sts_i.walk_need ? S_WALK : S_EMIT;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_fin) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit_row = 1'b1;
        state_d        = sts_i.d_last ? S_IDLE : S_EM_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/brf_dp.sv
`default_nettype none
module brf_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire brf_pkg::brf_req_t req_i,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_data_i,
  input  wire brf_pkg::brf_cmd_t cmd_i,
  output brf_pkg::brf_sts_t      sts_o,
  output logic                   res_valid_o,
  output brf_pkg::brf_res_t      res_o
);
  import brf_pkg::*;

  logic [6:0]          cfg_q;
  logic [NCNT_W-1:0]   n_eff, n_q;
  logic [1:0]          type_q;
  logic [5:0]          a_q, b_q;
  logic signed [15:0]  cost_q;

  logic [LCNT_W-1:0]   entries_q, i_q, k_q;
  logic                found_q;
  logic [LINK_W-1:0]   lt_mem [MAX_LINKS];
  logic [LINK_W-1:0]   lt_rdata_q;
  logic [5:0]          l_from, l_to;
  logic signed [15:0]  l_cost;
  logic                hit;

  logic [31:0]         dist_mem [NODES];
  logic signed [31:0]  dist_rdata_q;
  logic [NODE_AW-1:0]  dist_raddr;
  logic [NODES-1:0]    valid_q;
  logic [NODE_AW-1:0]  parent_q [NODES];

  logic [NCNT_W-1:0]   pass_q;
  logic                chk_q, neg_q;
  logic [NODE_AW-1:0]  eu_q, ev_q;
  logic signed [15:0]  ecost_q;
  logic signed [31:0]  cand_q;
  logic signed [32:0]  sum;
  logic signed [31:0]  sat_sum;
  logic                better;

  logic [NODE_AW-1:0]  d_q, cur_q, hop_q;
  logic [NCNT_W-1:0]   steps_q;
  logic [NODE_AW-1:0]  par;
  logic                d_local;

  logic                res_valid_q;
  brf_res_t            res_q;

  // clamp the router count to 1..NODES
  always_comb begin
    if (cfg_q == 7'd0) begin
      n_eff = NCNT_W'(1);
    end else if (cfg_q > 7'(NODES)) begin
      n_eff = NCNT_W'(NODES);
    end else begin
      n_eff = cfg_q[NCNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign l_from = lt_rdata_q[27:22];
  assign l_to   = lt_rdata_q[21:16];
  assign l_cost = lt_rdata_q[15:0];
  assign hit    = ((l_from == a_q) && (l_to == b_q)) || ((l_from == b_q) && (l_to == a_q));

  assign sum     = {dist_rdata_q[31], dist_rdata_q} + 33'(ecost_q);
  assign sat_sum = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                        : sum[31:0];
  assign better  = !valid_q[ev_q] || (cand_q < dist_rdata_q);
  assign par     = parent_q[cur_q];
  assign d_local = ({2'b0, d_q} == a_q);

  always_comb begin
    if (cmd_i.e1) begin
      dist_raddr = l_from[NODE_AW-1:0];
    end else if (cmd_i.e2) begin
      dist_raddr = ev_q;
    end else begin
      dist_raddr = d_q;
    end
  end

  // link table: registered read at the scan index
  always_ff @(posedge clk_i) begin
    lt_rdata_q <= lt_mem[i_q[LINK_AW-1:0]];
    if (cmd_i.add_wr0) begin
      lt_mem[entries_q[LINK_AW-1:0]] <= {a_q, b_q, cost_q};
    end else if (cmd_i.add_wr1) begin
      lt_mem[LINK_AW'(entries_q + LCNT_W'(1))] <= {b_q, a_q, cost_q};
    end else if (cmd_i.rm_step && !hit) begin
      lt_mem[k_q[LINK_AW-1:0]] <= lt_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_rdata_q <= dist_mem[dist_raddr];
    if (cmd_i.bf_init) begin
      dist_mem[a_q[NODE_AW-1:0]] <= '0;
    end else if (cmd_i.e3 && !chk_q && better) begin
      dist_mem[ev_q] <= cand_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      type_q <= req_i.req_type;
      a_q    <= req_i.node_a;
      b_q    <= req_i.node_b;
      cost_q <= req_i.link_cost;
      n_q    <= n_eff;
    end
    if (cmd_i.e1) begin
      eu_q    <= l_from[NODE_AW-1:0];
      ev_q    <= l_to[NODE_AW-1:0];
      ecost_q <= l_cost;
    end
    if (cmd_i.e2) begin
      cand_q <= sat_sum;
    end
    for (int j = 0; j < NODES; j++) begin
      if (cmd_i.bf_init) begin
        parent_q[j] <= '0;
      end
    end
    if (cmd_i.e3 && !chk_q && better) begin
      parent_q[ev_q] <= eu_q;
    end
    if (cmd_i.em_init) begin
      d_q <= '0;
    end else if (cmd_i.emit_row) begin
      d_q <= NODE_AW'(d_q + NODE_AW'(1));
    end
    if (cmd_i.walk_init) begin
      cur_q   <= d_q;
      steps_q <= '0;
    end else if (cmd_i.walk_step) begin
      if ({2'b0, par} == a_q) begin
        hop_q <= cur_q;
      end else if (steps_q + NCNT_W'(1) == n_q) begin
        hop_q <= d_q;
      end else begin
        cur_q   <= par;
        steps_q <= NCNT_W'(steps_q + NCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= '0;
      i_q         <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      valid_q     <= '0;
      pass_q      <= '0;
      chk_q       <= 1'b0;
      neg_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_row || cmd_i.emit_stat;
      if (cmd_i.add_wr1) begin
        entries_q <= LCNT_W'(entries_q + LCNT_W'(2));
      end else if (cmd_i.rm_commit && found_q) begin
        entries_q <= k_q;
      end
      if (cmd_i.idx_clr || cmd_i.bf_init || cmd_i.pass_next) begin
        i_q <= '0;
      end else if (cmd_i.rm_step || cmd_i.e3 || cmd_i.edge_skip) begin
        i_q <= LCNT_W'(i_q + LCNT_W'(1));
      end
      if (cmd_i.idx_clr) begin
        k_q     <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.rm_step) begin
        if (hit) begin
          found_q <= 1'b1;
        end else begin
          k_q <= LCNT_W'(k_q + LCNT_W'(1));
        end
      end
      if (cmd_i.bf_init) begin
        valid_q <= NODES'(1) << a_q[NODE_AW-1:0];
        pass_q  <= '0;
        chk_q   <= (n_q == NCNT_W'(1));
        neg_q   <= 1'b0;
      end else if (cmd_i.pass_next) begin
        pass_q <= NCNT_W'(pass_q + NCNT_W'(1));
        // last relaxing pass just ended: next one only checks
        if (pass_q + NCNT_W'(2) >= n_q) begin
          chk_q <= 1'b1;
        end
      end else if (cmd_i.e3) begin
        if (chk_q) begin
          neg_q <= neg_q | better;
        end else if (better) begin
          valid_q[ev_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stat) begin
      res_q <= '{status: cmd_i.stat_code, last: 1'b1, default: '0};
    end else if (cmd_i.emit_row) begin
      res_q.status     <= ST_OK;
      res_q.dest       <= 6'(d_q);
      res_q.reachable  <= valid_q[d_q];
      res_q.is_local   <= valid_q[d_q] && d_local;
      res_q.route_cost <= valid_q[d_q] ? dist_rdata_q : 32'sd0;
      res_q.next_hop   <= !valid_q[d_q] ? 6'd0 : (d_local ? a_q : 6'(hop_q));
      res_q.last       <= (d_q + NCNT_W'(1) == n_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    sts_o.req_type  = type_q;
    sts_o.bad       = (a_q >= 6'(n_q)) || ((type_q != REQ_COMPUTE) && (b_q >= 6'(n_q)));
    sts_o.full      = (entries_q + LCNT_W'(2) > LCNT_W'(MAX_LINKS))
                      || (entries_q > LCNT_W'(MAX_LINKS - 2));
    sts_o.i_end     = (i_q >= entries_q);
    sts_o.skip      = (l_from >= 6'(n_q)) || (l_to >= 6'(n_q))
                      || !valid_q[l_from[NODE_AW-1:0]];
    sts_o.chk       = chk_q;
    sts_o.neg       = neg_q;
    sts_o.walk_need = valid_q[d_q] && !d_local;
    sts_o.walk_fin  = ({2'b0, par} == a_q) || (steps_q + NCNT_W'(1) == n_q);
    sts_o.d_last    = (d_q + NCNT_W'(1) == n_q);
    sts_o.found     = found_q;
  end

endmodule
`default_nettype wire

>>> rtl/core/bellman_ford_routing_table.sv
// Channel  | Ports                               | Handshake
// request  | start_i, busy_o, req_i              | taken when start_i & !busy_o
// result   | res_valid_o, res_o                  | one-cycle strobe, no stall
// config   | cfg_we_i, cfg_data_i (node_count)   | written when cfg_we_i is high
//
// Add writes both directions of the link; remove scans every table entry. Compute runs
// n-1 relaxing passes plus a check pass, each over every link entry
// (link table read, then distance read of both ends through one port),
// then emits one routing row per router, after a next-hop walk where needed.
// Reset clears the link count and control; no clearing pass.
// Results are delivered one per strobe and cannot be held off.
`default_nettype none
module bellman_ford_routing_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire brf_pkg::brf_req_t req_i,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_data_i,
  output logic                   res_valid_o,
  output brf_pkg::brf_res_t      res_o
);
  import brf_pkg::*;

  brf_cmd_t cmd;
  brf_sts_t sts;

  brf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  brf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_bellman_ford_routing_table.sv
`default_nettype none
module tb_bellman_ford_routing_table;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int NMAX = 16;
  localparam int LMAX = 128;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  brf_req_t req_i = '0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  logic res_valid_o;
  brf_res_t res_o;

  bellman_ford_routing_table u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i,
    .cfg_we_i, .cfg_data_i, .res_valid_o, .res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block state
  logic [5:0]         lk_from [LMAX];
  logic [5:0]         lk_to   [LMAX];
  logic signed [31:0] lk_cost [LMAX];
  int                 lk_cnt;
  logic [6:0]         ncount;
  logic signed [31:0] sh_dist [NMAX];
  bit                 dvalid [NMAX];
  int                 parent [NMAX];

  brf_res_t pending_rows[$];
  int errors;
  int sender_idle;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void queue_word(input brf_res_t r);
    pending_rows.insert(pending_rows.size(), r);
  endfunction

  function automatic int used_nodes();
    int n;
    n = int'(ncount);
    if (n < 1) n = 1;
    if (n > NMAX) n = NMAX;
    return n;
  endfunction

  function automatic brf_res_t status_word(input logic [2:0] st);
    brf_res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic bit relax_once(input int n, input bit apply);
    bit any;
    int u, v;
    logic signed [31:0] cand;
    any = 0;
    for (int i = 0; i < lk_cnt; i++) begin
      u = int'(lk_from[i]);
      v = int'(lk_to[i]);
      if (u >= n || v >= n || !dvalid[u]) continue;
      cand = sat_sum(sh_dist[u], lk_cost[i]);
      if (!dvalid[v] || cand < sh_dist[v]) begin
        any = 1;
        if (apply) begin
          sh_dist[v] = cand;
          dvalid[v] = 1;
          parent[v] = u;
        end
      end
    end
    return any;
  endfunction

  function automatic int first_hop(input int d, input int src, input int n);
    int cur, p;
    cur = d;
    for (int s = 0; s < n; s++) begin
      p = parent[cur % NMAX];
      if (p == src) return cur;
      cur = p;
    end
    return d;
  endfunction

  // update shadow state and queue the expected rows
  task automatic predict_routes(input brf_req_t rq);
    int n, a, b, k;
    bit found;
    brf_res_t r;
    n = used_nodes();
    a = int'(rq.node_a);
    b = int'(rq.node_b);
    case (rq.req_type)
      REQ_ADD: begin
        if (a >= n || b >= n) queue_word(status_word(ST_BAD_NODE));
        else if (lk_cnt + 2 > LMAX) queue_word(status_word(ST_FULL));
        else begin
          lk_from[lk_cnt] = 6'(a); lk_to[lk_cnt] = 6'(b); lk_cost[lk_cnt] = rq.link_cost;
          lk_cnt++;
          lk_from[lk_cnt] = 6'(b); lk_to[lk_cnt] = 6'(a); lk_cost[lk_cnt] = rq.link_cost;
          lk_cnt++;
          queue_word(status_word(ST_OK));
        end
      end
      REQ_REMOVE: begin
        if (a >= n || b >= n) queue_word(status_word(ST_BAD_NODE));
        else begin
          k = 0;
          found = 0;
          for (int i = 0; i < lk_cnt; i++) begin
            if ((lk_from[i] == a && lk_to[i] == b) || (lk_from[i] == b && lk_to[i] == a)) begin
              found = 1;
              continue;
            end
            lk_from[k] = lk_from[i]; lk_to[k] = lk_to[i]; lk_cost[k] = lk_cost[i];
            k++;
          end
          if (found) begin
            lk_cnt = k;
            queue_word(status_word(ST_OK));
          end else queue_word(status_word(ST_NOT_FOUND));
        end
      end
      REQ_COMPUTE: begin
        if (a >= n) queue_word(status_word(ST_BAD_NODE));
        else begin
          for (int i = 0; i < NMAX; i++) begin
            sh_dist[i] = 0; dvalid[i] = 0; parent[i] = 0;
          end
          dvalid[a] = 1;
          for (int p = 0; p + 1 < n; p++) void'(relax_once(n, 1));
          if (relax_once(n, 0)) queue_word(status_word(ST_NEG_CYCLE));
          else begin
            for (int d = 0; d < n; d++) begin
              r = '0;
              r.status = ST_OK;
              r.dest = 6'(d);
              r.last = (d + 1 == n);
              if (dvalid[d]) begin
                r.reachable = 1;
                r.route_cost = sh_dist[d];
                r.is_local = (d == a);
                r.next_hop = 6'((d == a) ? a : first_hop(d, a, n));
              end
              queue_word(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    brf_res_t w;
    if (rst_ni && res_valid_o) begin
      if (pending_rows.size() == 0) report_mismatch("unexpected result word");
      else begin
        w = pending_rows.pop_front();
        if (res_o.status !== w.status)
          report_mismatch($sformatf("status %0d exp %0d", res_o.status, w.status));
        if (res_o.dest !== w.dest)
          report_mismatch($sformatf("dest %0d exp %0d", res_o.dest, w.dest));
        if (res_o.reachable !== w.reachable)
          report_mismatch($sformatf("reachable %0b exp %0b dest %0d",
                                    res_o.reachable, w.reachable, w.dest));
        if (res_o.is_local !== w.is_local)
          report_mismatch($sformatf("is_local %0b exp %0b dest %0d",
                                    res_o.is_local, w.is_local, w.dest));
        if (res_o.route_cost !== w.route_cost)
          report_mismatch($sformatf("route_cost %0d exp %0d dest %0d",
                                    res_o.route_cost, w.route_cost, w.dest));
        if (res_o.next_hop !== w.next_hop)
          report_mismatch($sformatf("next_hop %0d exp %0d dest %0d",
                                    res_o.next_hop, w.next_hop, w.dest));
        if (res_o.last !== w.last)
          report_mismatch($sformatf("last %0b exp %0b", res_o.last, w.last));
      end
    end
  end

  // hold start until the word is taken; keep start low at least one cycle between words
  task automatic send_req(input brf_req_t rq);
    do @(negedge clk_i);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle);
    start_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_routes(rq);
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic write_count(input logic [6:0] v);
    while (pending_rows.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ncount = v;
  endtask

  function automatic brf_req_t mk(input logic [1:0] t, input int a, input int b,
                                  input int c);
    brf_req_t r;
    r.req_type = t;
    r.node_a = 6'(a);
    r.node_b = 6'(b);
    r.link_cost = 16'(c);
    return r;
  endfunction

  function automatic brf_req_t rand_req(input int n, input int mix);
    brf_req_t r;
    int p;
    p = $urandom_range(99);
    if (p < 3) r.req_type = REQ_UNUSED;
    else if (p < 45) r.req_type = REQ_ADD;
    else if (p < 65) r.req_type = REQ_REMOVE;
    else r.req_type = REQ_COMPUTE;
    // mostly in-range routers, a few anywhere
    if ($urandom_range(99) < 8) begin
      r.node_a = 6'($urandom_range(63));
      r.node_b = 6'($urandom_range(63));
    end else begin
      r.node_a = 6'($urandom_range(n - 1));
      r.node_b = 6'($urandom_range(n - 1));
    end
    case (mix)
      0: r.link_cost = 16'($urandom_range(20));
      1: r.link_cost = 16'($urandom_range(65535));
      default: r.link_cost = 16'($urandom_range(40) - 3);
    endcase
    return r;
  endfunction

  typedef struct {
    brf_req_t rq;
    bit       has_exp;
    logic [2:0] exp_status;
  } dir_row_t;

  initial begin
    dir_row_t plan[$];
    brf_res_t ex;
    int n;
    logic [6:0] counts [5];
    counts = '{7'd4, 7'd1, 7'd127, 7'd0, 7'd16};
    errors = 0;
    sender_idle = 0;
    lk_cnt = 0;
    ncount = NODE_COUNT_RST;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    plan.insert(plan.size(), dir_row_t'{mk(REQ_COMPUTE, 63, 0, 0), 1, ST_BAD_NODE});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 0, 16, 5), 1, ST_BAD_NODE});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_REMOVE, 0, 1, 0), 1, ST_NOT_FOUND});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_COMPUTE, 0, 0, 0), 0, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 0, 1, 32767), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 1, 15, 32767), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 15, 2, -32768), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_COMPUTE, 0, 0, 0), 0, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_REMOVE, 2, 15, 0), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 3, 4, 7), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 4, 3, 2), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_COMPUTE, 15, 63, -1), 0, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_REMOVE, 4, 3, 0), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_UNUSED, 42, 21, 12345), 0, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_ADD, 5, 6, -1), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_COMPUTE, 5, 0, 0), 1, ST_NEG_CYCLE});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_REMOVE, 6, 5, 0), 1, ST_OK});
    plan.insert(plan.size(), dir_row_t'{mk(REQ_COMPUTE, 1, 0, 0), 0, ST_OK});
    foreach (plan[i]) begin
      if (plan[i].has_exp) begin
        ex = status_word(plan[i].exp_status);
        send_req(plan[i].rq);
        if (pending_rows.size() == 0 || pending_rows[$] !== ex)
          report_mismatch($sformatf("directed row %0d status prediction", i));
      end else send_req(plan[i].rq);
    end

    // fill the table to check the full case at a small size
    write_count(7'd4);
    while (lk_cnt + 2 <= LMAX) send_req(mk(REQ_ADD, $urandom_range(3), $urandom_range(3),
                                           $urandom_range(65535)));
    send_req(mk(REQ_ADD, 0, 1, 1));
    send_req(mk(REQ_COMPUTE, 2, 0, 0));
    for (int i = 0; i < 4; i++)
      for (int j = i; j < 4; j++) send_req(mk(REQ_REMOVE, i, j, 0));

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle = (ph == 0) ? 38 : (ph == 1) ? 70 : 0;
      for (int s = 0; s < 5; s++) begin
        write_count(counts[s]);
        n = used_nodes();
        for (int k = 0; k < 11; k++) send_req(rand_req(n, (s + k) % 3));
        if (lk_cnt > 60)
          for (int i = 0; i < n; i++) send_req(mk(REQ_REMOVE, i, $urandom_range(n - 1), 0));
      end
    end

    while (pending_rows.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending_rows.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
